// File: rtl/ccc_pkg.sv
`timescale 1ns / 1ps
// ccc_pkg: shared types, constants and calendar helpers for the clock calendar counter
// no dependencies

package ccc_pkg;

    // field widths
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int YEAR_W   = 14;
    localparam int H12_W    = 4;

    // action codes
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    // time and calendar limits
    localparam logic [HOUR_W-1:0]   HOURS_PER_DAY = 5'd24;
    localparam logic [HOUR_W-1:0]   NOON_HOUR     = 5'd12;
    localparam logic [MINUTE_W-1:0] MINUTES_PER_H = 6'd60;
    localparam logic [SECOND_W-1:0] SECONDS_PER_M = 6'd60;
    localparam logic [MONTH_W-1:0]  LAST_MONTH    = 4'd12;
    localparam logic [YEAR_W-1:0]   MAX_YEAR      = 14'd9999;

    // reset and load defaults
    localparam logic [DAY_W-1:0]   DEFAULT_DAY   = 5'd1;
    localparam logic [MONTH_W-1:0] DEFAULT_MONTH = 4'd1;
    localparam logic [YEAR_W-1:0]  DEFAULT_YEAR  = 14'd2000;

    typedef struct packed {
        logic                action;
        logic [HOUR_W-1:0]   set_hour;
        logic [MINUTE_W-1:0] set_minute;
        logic [SECOND_W-1:0] set_second;
        logic [MONTH_W-1:0]  set_month;
        logic [DAY_W-1:0]    set_day;
        logic [YEAR_W-1:0]   set_year;
    } in_item_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour_now;
        logic [MINUTE_W-1:0] minute_now;
        logic [SECOND_W-1:0] second_now;
        logic [MONTH_W-1:0]  month_now;
        logic [DAY_W-1:0]    day_now;
        logic [YEAR_W-1:0]   year_now;
        logic [H12_W-1:0]    hour_twelve;
        logic                is_pm;
    } out_item_t;

    // divisible by four and nonzero, no century rule
    function automatic logic leap_year(input logic [YEAR_W-1:0] y);
        return (y[1:0] == 2'b00) && (y != '0);
    endfunction

    // days in month m (1..12) of year y
    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic [YEAR_W-1:0] y);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                      len = leap_year(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/ccc_if.sv
`timescale 1ns / 1ps
// ccc_req_if / ccc_rsp_if: valid-ready channels for input and result items
// depends on ccc_pkg for the payload structs

interface ccc_req_if;
    logic              valid;
    logic              ready;
    ccc_pkg::in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface ccc_rsp_if;
    logic               valid;
    logic               ready;
    ccc_pkg::out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// File: rtl/clock_calendar_counter.sv
`timescale 1ns / 1ps
// clock_calendar_counter: time of day and calendar date kept in counters
// depends on ccc_pkg and the channel interfaces in ccc_if.sv

// Each item either advances the time by one second (carrying into minutes,
// hours, day, month and year, with the year holding at 9999) or loads a new
// time and date, where out-of-range fields fall back to 0, 1 or 2000 and a
// day beyond the loaded month's length becomes 1. Every item returns one
// result with the updated time and date plus the 12-hour form and a PM flag.
// An item is registered on entry in the input register and its result is then
// held in the output register until taken; one item is taken every cycle while
// results are taken, and a stalled result holds the input register and then the
// input until the result side is ready again.
module clock_calendar_counter (
    input  logic        clk,
    input  logic        rst_n,
    ccc_req_if.sink     req,
    ccc_rsp_if.source   rsp
);

    // input register
    logic              in_valid_reg;
    ccc_pkg::in_item_t in_item_reg;

    // time and date counters
    logic [ccc_pkg::SECOND_W-1:0] sec_reg,   sec_next;
    logic [ccc_pkg::MINUTE_W-1:0] min_reg,   min_next;
    logic [ccc_pkg::HOUR_W-1:0]   hour_reg,  hour_next;
    logic [ccc_pkg::DAY_W-1:0]    day_reg,   day_next;
    logic [ccc_pkg::MONTH_W-1:0]  month_reg, month_next;
    logic [ccc_pkg::YEAR_W-1:0]   year_reg,  year_next;

    // result register
    logic               out_valid_reg;
    ccc_pkg::out_item_t out_item_reg, out_item_next;

    logic advance;

    // handshake
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign rsp.valid = out_valid_reg;
    assign rsp.item  = out_item_reg;

    // next counter values for a tick or a load
    always_comb
    begin
        logic carry_min;
        logic carry_hour;
        logic carry_day;
        logic carry_month;
        logic carry_year;
        logic [ccc_pkg::MONTH_W-1:0] ld_month;
        logic [ccc_pkg::YEAR_W-1:0]  ld_year;

        carry_min   = 1'b0;
        carry_hour  = 1'b0;
        carry_day   = 1'b0;
        carry_month = 1'b0;
        carry_year  = 1'b0;
        ld_month    = ccc_pkg::DEFAULT_MONTH;
        ld_year     = ccc_pkg::DEFAULT_YEAR;

        sec_next   = sec_reg;
        min_next   = min_reg;
        hour_next  = hour_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;

        if (in_item_reg.action == ccc_pkg::ACT_LOAD)
        begin
            // validated load
            hour_next = (in_item_reg.set_hour < ccc_pkg::HOURS_PER_DAY) ?
                        in_item_reg.set_hour : '0;
            min_next  = (in_item_reg.set_minute < ccc_pkg::MINUTES_PER_H) ?
                        in_item_reg.set_minute : '0;
            sec_next  = (in_item_reg.set_second < ccc_pkg::SECONDS_PER_M) ?
                        in_item_reg.set_second : '0;
            if (in_item_reg.set_year != '0 && in_item_reg.set_year <= ccc_pkg::MAX_YEAR)
                ld_year = in_item_reg.set_year;
            if (in_item_reg.set_month != '0 && in_item_reg.set_month <= ccc_pkg::LAST_MONTH)
                ld_month = in_item_reg.set_month;
            year_next  = ld_year;
            month_next = ld_month;
            day_next   = (in_item_reg.set_day != '0 &&
                          in_item_reg.set_day <= ccc_pkg::month_length(ld_month, ld_year)) ?
                         in_item_reg.set_day : ccc_pkg::DEFAULT_DAY;
        end
        else
        begin
            // carry chain of one second tick
            carry_min   = (sec_reg == ccc_pkg::SECONDS_PER_M - 6'd1);
            carry_hour  = carry_min && (min_reg == ccc_pkg::MINUTES_PER_H - 6'd1);
            carry_day   = carry_hour && (hour_reg == ccc_pkg::HOURS_PER_DAY - 5'd1);
            carry_month = carry_day &&
                          (day_reg == ccc_pkg::month_length(month_reg, year_reg));
            carry_year  = carry_month && (month_reg == ccc_pkg::LAST_MONTH);

            sec_next = carry_min ? '0 : sec_reg + 6'd1;
            if (carry_min)
                min_next = carry_hour ? '0 : min_reg + 6'd1;
            if (carry_hour)
                hour_next = carry_day ? '0 : hour_reg + 5'd1;
            if (carry_day)
                day_next = carry_month ? ccc_pkg::DEFAULT_DAY : day_reg + 5'd1;
            if (carry_month)
                month_next = carry_year ? ccc_pkg::DEFAULT_MONTH : month_reg + 4'd1;
            if (carry_year && year_reg < ccc_pkg::MAX_YEAR)
                year_next = year_reg + 14'd1;
        end
    end

    // result fields from the updated counters
    always_comb
    begin
        logic [ccc_pkg::HOUR_W-1:0] h12;

        if (hour_next == '0)
            h12 = ccc_pkg::NOON_HOUR;
        else if (hour_next > ccc_pkg::NOON_HOUR)
            h12 = hour_next - ccc_pkg::NOON_HOUR;
        else
            h12 = hour_next;

        out_item_next.hour_now    = hour_next;
        out_item_next.minute_now  = min_next;
        out_item_next.second_now  = sec_next;
        out_item_next.month_now   = month_next;
        out_item_next.day_now     = day_next;
        out_item_next.year_now    = year_next;
        out_item_next.hour_twelve = h12[ccc_pkg::H12_W-1:0];
        out_item_next.is_pm       = (hour_next >= ccc_pkg::NOON_HOUR);
    end

    // control and counter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sec_reg       <= '0;
            min_reg       <= '0;
            hour_reg      <= '0;
            day_reg       <= ccc_pkg::DEFAULT_DAY;
            month_reg     <= ccc_pkg::DEFAULT_MONTH;
            year_reg      <= ccc_pkg::DEFAULT_YEAR;
        end
        else
        begin
            if (req.ready)
                in_valid_reg <= req.valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                sec_reg       <= sec_next;
                min_reg       <= min_next;
                hour_reg      <= hour_next;
                day_reg       <= day_next;
                month_reg     <= month_next;
                year_reg      <= year_next;
            end
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
            in_item_reg <= req.item;
        if (advance)
            out_item_reg <= out_item_next;
    end

endmodule

// File: tb/clock_calendar_counter_tb.sv
`timescale 1ns / 1ps
// clock_calendar_counter_tb: self-checking bench for the clock calendar counter
// depends on ccc_pkg, the channel interfaces in ccc_if.sv and the counter itself

module clock_calendar_counter_tb;

    localparam int ITEM_GOAL  = 1600;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_WAIT = 10;

    // tracks the expected time and date and holds the readings still owed
    class calendar_tracker;
        logic [ccc_pkg::HOUR_W-1:0]   hr;
        logic [ccc_pkg::MINUTE_W-1:0] mi;
        logic [ccc_pkg::SECOND_W-1:0] se;
        logic [ccc_pkg::DAY_W-1:0]    dy;
        logic [ccc_pkg::MONTH_W-1:0]  mo;
        logic [ccc_pkg::YEAR_W-1:0]   yr;
        ccc_pkg::out_item_t           expected_readings[$];
        int                           failures;

        function new();
            hr = '0;
            mi = '0;
            se = '0;
            dy = ccc_pkg::DEFAULT_DAY;
            mo = ccc_pkg::DEFAULT_MONTH;
            yr = ccc_pkg::DEFAULT_YEAR;
            failures = 0;
        endfunction

        // month length, leap every fourth year with no century rule
        function int days_in(input int m, input int y);
            if (m == 2)
                return ((y % 4 == 0) && (y > 0)) ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            return 31;
        endfunction

        // one second forward with carries up to the year, year holds at the top
        function void tick();
            se = se + 1'b1;
            if (se < ccc_pkg::SECONDS_PER_M)
                return;
            se = '0;
            mi = mi + 1'b1;
            if (mi < ccc_pkg::MINUTES_PER_H)
                return;
            mi = '0;
            hr = hr + 1'b1;
            if (hr < ccc_pkg::HOURS_PER_DAY)
                return;
            hr = '0;
            // day compared in int so day 31 does not wrap the counter width
            if (int'(dy) + 1 <= days_in(mo, yr))
            begin
                dy = dy + 1'b1;
                return;
            end
            dy = ccc_pkg::DEFAULT_DAY;
            mo = mo + 1'b1;
            if (mo <= ccc_pkg::LAST_MONTH)
                return;
            mo = ccc_pkg::DEFAULT_MONTH;
            if (yr < ccc_pkg::MAX_YEAR)
                yr = yr + 1'b1;
        endfunction

        // load with range checks, the day checked against the month and year kept
        function void load(input ccc_pkg::in_item_t it);
            hr = (it.set_hour < ccc_pkg::HOURS_PER_DAY) ? it.set_hour : '0;
            mi = (it.set_minute < ccc_pkg::MINUTES_PER_H) ? it.set_minute : '0;
            se = (it.set_second < ccc_pkg::SECONDS_PER_M) ? it.set_second : '0;
            yr = (it.set_year >= 1 && it.set_year <= ccc_pkg::MAX_YEAR) ? it.set_year
                                                                        : ccc_pkg::DEFAULT_YEAR;
            mo = (it.set_month >= 1 && it.set_month <= ccc_pkg::LAST_MONTH) ? it.set_month
                                                                   : ccc_pkg::DEFAULT_MONTH;
            dy = (it.set_day >= 1 && int'(it.set_day) <= days_in(mo, yr)) ? it.set_day
                                                                   : ccc_pkg::DEFAULT_DAY;
        endfunction

        // accepted input item: update the calendar and queue the reading
        function void note_request(input ccc_pkg::in_item_t it);
            ccc_pkg::out_item_t r;
            int                 h12;
            if (it.action == ccc_pkg::ACT_LOAD)
                load(it);
            else
                tick();
            h12 = (hr == 0 || hr == ccc_pkg::NOON_HOUR) ? 12 : int'(hr) % 12;
            r.hour_now    = hr;
            r.minute_now  = mi;
            r.second_now  = se;
            r.month_now   = mo;
            r.day_now     = dy;
            r.year_now    = yr;
            r.hour_twelve = h12[ccc_pkg::H12_W-1:0];
            r.is_pm       = (hr >= ccc_pkg::NOON_HOUR);
            expected_readings.push_back(r);
        endfunction

        function void compare_field(input string field, input int want, input int got);
            if (want != got)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
                failures++;
            end
        endfunction

        // accepted result item against the oldest reading owed
        function void check_reading(input ccc_pkg::out_item_t got);
            ccc_pkg::out_item_t want;
            if (expected_readings.size() == 0)
            begin
                $display("%0t: reading with none expected, actual %h", $time, got);
                failures++;
                return;
            end
            want = expected_readings.pop_front();
            compare_field("hour_now", want.hour_now, got.hour_now);
            compare_field("minute_now", want.minute_now, got.minute_now);
            compare_field("second_now", want.second_now, got.second_now);
            compare_field("month_now", want.month_now, got.month_now);
            compare_field("day_now", want.day_now, got.day_now);
            compare_field("year_now", want.year_now, got.year_now);
            compare_field("hour_twelve", want.hour_twelve, got.hour_twelve);
            compare_field("is_pm", want.is_pm, got.is_pm);
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   sent_count;
    int   idle_cycles;

    calendar_tracker tracker;

    ccc_req_if req_ch();
    ccc_rsp_if rsp_ch();

    clock_calendar_counter uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // idle gap per item, with every fourth stretch of items running flat out
    function automatic int draw_gap(input int n);
        if ((n / 48) % 4 == 3)
            return 0;
        return int'($urandom_range(0, 11));
    endfunction

    // random bits across the whole input item
    function automatic ccc_pkg::in_item_t random_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(ccc_pkg::in_item_t)-1:0];
    endfunction

    // present one item after a random gap and wait for it to be taken
    task automatic send_request(input ccc_pkg::in_item_t it);
        int gap;
        gap = draw_gap(sent_count);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.item  <= it;
        req_ch.valid <= 1'b1;
        do @(posedge clk); while (!req_ch.ready);
        tracker.note_request(it);
        sent_count++;
    endtask

    task automatic load_time(input int h, input int m, input int s,
                             input int mon, input int d, input int y);
        ccc_pkg::in_item_t it;
        it.action     = ccc_pkg::ACT_LOAD;
        it.set_hour   = h[ccc_pkg::HOUR_W-1:0];
        it.set_minute = m[ccc_pkg::MINUTE_W-1:0];
        it.set_second = s[ccc_pkg::SECOND_W-1:0];
        it.set_month  = mon[ccc_pkg::MONTH_W-1:0];
        it.set_day    = d[ccc_pkg::DAY_W-1:0];
        it.set_year   = y[ccc_pkg::YEAR_W-1:0];
        send_request(it);
    endtask

    // tick with junk in the load fields, which must be ignored
    task automatic tick_once();
        ccc_pkg::in_item_t it;
        it = random_item();
        it.action = ccc_pkg::ACT_TICK;
        send_request(it);
    endtask

    task automatic run_directed();
        tick_once();
        // end of the last year: time and date wrap, year holds
        load_time(23, 59, 59, 12, 31, 9999);
        tick_once();
        // leap day, month ends and minute carry
        load_time(23, 59, 59, 2, 28, 2004);
        tick_once();
        load_time(23, 59, 59, 2, 29, 2004);
        tick_once();
        load_time(23, 59, 59, 2, 28, 2001);
        tick_once();
        load_time(23, 59, 59, 4, 30, 2001);
        tick_once();
        load_time(11, 59, 59, 12, 31, 1999);
        tick_once();
        // out-of-range time fields
        load_time(24, 60, 60, 6, 15, 1);
        load_time(31, 63, 63, 7, 31, 9999);
        // out-of-range month, year and day
        load_time(12, 0, 0, 0, 31, 0);
        load_time(13, 1, 1, 13, 29, 10000);
        load_time(0, 2, 2, 15, 0, 16383);
        load_time(1, 3, 3, 4, 31, 2023);
        load_time(22, 4, 4, 2, 30, 2024);
        load_time(10, 5, 5, 2, 29, 2001);
        // bad year defaults to a leap year so the leap day stays
        load_time(23, 6, 6, 2, 29, 0);
        load_time(9, 7, 7, 2, 29, 4);
    endtask

    // mostly loads near a rollover then ticks, plus free ticks, raw and in-range loads
    task automatic run_random();
        int done;
        int pick;
        int runs;
        int y;
        ccc_pkg::in_item_t it;
        done = 0;
        while (done < ITEM_GOAL)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 2)
            begin
                case ($urandom_range(0, 2))
                    0: y = 9999;
                    1: y = 4 * $urandom_range(1, 2499);
                    default: y = $urandom_range(1, 9999);
                endcase
                load_time(($urandom_range(0, 3) == 0) ? $urandom_range(0, 23) : 23,
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 59) : 59,
                          $urandom_range(55, 59), $urandom_range(1, 12),
                          $urandom_range(27, 31), y);
                runs = $urandom_range(1, 6);
                done += 1 + runs;
                repeat (runs) tick_once();
            end
            else if (pick <= 6)
            begin
                tick_once();
                done++;
            end
            else if (pick <= 8)
            begin
                it = random_item();
                it.action = ccc_pkg::ACT_LOAD;
                send_request(it);
                done++;
            end
            else
            begin
                load_time($urandom_range(0, 23), $urandom_range(0, 59),
                          $urandom_range(0, 59), $urandom_range(1, 12),
                          $urandom_range(1, 31), $urandom_range(1, 9999));
                done++;
            end
        end
    endtask

    // reset, stimulus, drain and verdict
    initial
    begin
        tracker      = new();
        sent_count   = 0;
        rst_n        = 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.item  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        req_ch.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (tracker.failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // result side with random stalls
    initial
    begin
        int stall;
        int taken;
        taken = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap(taken + 17);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            tracker.check_reading(rsp_ch.item);
            taken++;
        end
    end

    // watchdog on cycles without any item moving
    initial idle_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule
